@@ design/pkb_dec_pkg.sv @@
// PackBits scanline decoder: shared types, widths and constants.
// No dependencies; imported by the interfaces and all modules.

package pkb_dec_pkg;

    localparam int MAX_WIDTH = 16384;
    localparam int POS_LIMIT = 16384;
    localparam int W_CAP     = (MAX_WIDTH > POS_LIMIT) ? POS_LIMIT : MAX_WIDTH;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;
    localparam int SP_W   = 14;
    localparam int POS_W  = 15;
    localparam int LW_W   = 15;

    localparam logic [LW_W-1:0]   LW_RESET = LW_W'(16384);
    localparam logic [POS_W-1:0]  CAP_VAL  = POS_W'(W_CAP);
    localparam logic [BYTE_W-1:0] HDR_NOP  = 8'd128;
    localparam logic [8:0]        REP_BASE = 9'd257;

    typedef enum logic [3:0] {
        PH_DONE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_REPEAT  = 4'b0100,
        PH_LITERAL = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [LEN_W-1:0]   literal_left;
        logic [LEN_W-1:0]   repeat_count;
        logic [POS_W-1:0]   position;
    } t_state;

    typedef struct packed {
        logic [SP_W-1:0]    start_pos;
        logic [LEN_W-1:0]   run_length;
        logic [BYTE_W-1:0]  pixel_value;
        logic               line_full;
    } t_result;

endpackage

@@ design/pkb_dec_in_if.sv @@
// Input byte channel: valid/ready plus one compressed byte and line start flag.
// Depends on pkb_dec_pkg.

interface pkb_dec_in_if import pkb_dec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              line_start;

    modport source (output valid, output data_byte, output line_start, input ready);
    modport sink   (input valid, input data_byte, input line_start, output ready);
endinterface

@@ design/pkb_dec_out_if.sv @@
// Run descriptor channel: valid/ready plus start position, length, value, line full.
// Depends on pkb_dec_pkg.

interface pkb_dec_out_if import pkb_dec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SP_W-1:0]   start_pos;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] pixel_value;
    logic              line_full;

    modport source (output valid, output start_pos, output run_length,
                    output pixel_value, output line_full, input ready);
    modport sink   (input valid, input start_pos, input run_length,
                    input pixel_value, input line_full, output ready);
endinterface

@@ design/pkb_dec_cfg_if.sv @@
// Configuration write channel: valid/ready plus line width write data.
// Depends on pkb_dec_pkg.

interface pkb_dec_cfg_if import pkb_dec_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [LW_W-1:0] line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

@@ design/pkb_dec_step.sv @@
// Combinational decode of one byte: next phase/counts/position and run descriptor.
// Depends on pkb_dec_pkg.

module pkb_dec_step
    import pkb_dec_pkg::*;
(
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_line_start,
    input  logic [LW_W-1:0]   i_line_width,
    output t_state            o_state,
    output logic              o_emit,
    output t_result           o_result
);

    logic [POS_W-1:0] w;
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] new_pos;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lit_dec;
    logic [8:0]       rep_full;
    t_state           cur;

    always_comb begin
        if (i_line_width > CAP_VAL) begin
            w = CAP_VAL;
        end else if (i_line_width == '0) begin
            w = POS_W'(1);
        end else begin
            w = i_line_width;
        end
    end

    always_comb begin
        cur = i_state;
        if (i_line_start) begin
            cur.phase        = PH_HEADER;
            cur.literal_left = '0;
            cur.repeat_count = '0;
            cur.position     = '0;
        end
    end

    assign room     = w - cur.position;
    assign rep_full = REP_BASE - {1'b0, i_data_byte};
    assign lit_dec  = (cur.literal_left != '0) ? cur.literal_left - LEN_W'(1)
                                                : cur.literal_left;

    always_comb begin
        if (cur.phase == PH_REPEAT) begin
            len = ({7'b0, cur.repeat_count} > room) ? room[LEN_W-1:0] : cur.repeat_count;
        end else begin
            len = LEN_W'(1);
        end
    end

    assign new_pos = cur.position + {7'b0, len};

    always_comb begin
        o_state = cur;
        o_emit  = 1'b0;
        o_result.start_pos   = cur.position[SP_W-1:0];
        o_result.run_length  = len;
        o_result.pixel_value = i_data_byte;
        o_result.line_full   = (new_pos >= w);
        if (cur.phase != PH_DONE) begin
            if (cur.position >= w) begin
                o_state.phase = PH_DONE;
            end else begin
                case (cur.phase)
                    PH_HEADER: begin
                        if (i_data_byte > HDR_NOP) begin
                            o_state.repeat_count = rep_full[LEN_W-1:0];
                            o_state.phase        = PH_REPEAT;
                        end else if (i_data_byte < HDR_NOP) begin
                            o_state.literal_left = i_data_byte + LEN_W'(1);
                            o_state.phase        = PH_LITERAL;
                        end
                    end
                    PH_REPEAT: begin
                        o_emit               = 1'b1;
                        o_state.position     = new_pos;
                        o_state.repeat_count = '0;
                        o_state.phase        = (new_pos >= w) ? PH_DONE : PH_HEADER;
                    end
                    PH_LITERAL: begin
                        o_emit               = 1'b1;
                        o_state.position     = new_pos;
                        o_state.literal_left = lit_dec;
                        if (new_pos >= w) begin
                            o_state.phase = PH_DONE;
                        end else if (lit_dec == '0) begin
                            o_state.phase = PH_HEADER;
                        end
                    end
                    default: begin
                        o_state.phase = PH_DONE;
                    end
                endcase
            end
        end
    end

endmodule

@@ design/packbits_scanline_decoder_top.sv @@
// PackBits scanline decoder top: input register, decoder state, result register.
// Depends on pkb_dec_pkg, the channel interfaces and pkb_dec_step.
//
//  channel  | dir | payload                                         | handshake
//  i_in     | in  | data_byte[7:0], line_start                      | valid/ready
//  o_out    | out | start_pos[13:0], run_length[7:0], pixel_value, line_full | valid/ready
//  i_cfg    | in  | line_width[14:0]                                | valid/ready
//
// One byte per cycle unless output stalls; descriptors go via input and result registers.
// State updates as a byte leaves the input register; only runs enter the result register.
// Output stall holds the result register and the input register; i_in.ready drops
// only while both are occupied. No clearing pass; config is always ready.
// Reset: synchronous active low; width returns to 16384, line counts as done.

module packbits_scanline_decoder_top
    import pkb_dec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pkb_dec_in_if.sink    i_in,
    pkb_dec_cfg_if.sink   i_cfg,
    pkb_dec_out_if.source o_out
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_data_byte;
    logic              r_line_start;
    t_state            r_state;
    t_state            n_state;
    logic [LW_W-1:0]   r_line_width;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              n_emit;
    logic              adv;

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    pkb_dec_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_data_byte),
        .i_line_start (r_line_start),
        .i_line_width (r_line_width),
        .o_state      (n_state),
        .o_emit       (n_emit),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_line_width         <= LW_RESET;
            r_state.phase        <= PH_DONE;
            r_state.literal_left <= '0;
            r_state.repeat_count <= '0;
            r_state.position     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_line_width <= i_cfg.line_width;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && n_emit;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data_byte  <= i_in.data_byte;
            r_line_start <= i_in.line_start;
        end
        if (adv && r_in_valid && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.start_pos   = r_result.start_pos;
    assign o_out.run_length  = r_result.run_length;
    assign o_out.pixel_value = r_result.pixel_value;
    assign o_out.line_full   = r_result.line_full;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.position <= CAP_VAL)
        else $error("position beyond line capacity");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.run_length != '0))
        else $error("empty run emitted");

    a_full_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && n_emit && n_result.line_full) |=> (r_state.phase == PH_DONE))
        else $error("line full but decoder not done");

endmodule
